// ===== rtl/tkhyst_pkg.sv =====
// Package for the touch keypad hysteresis thermostat.
// Holds register map, op codes, reset values and the result word type.
// No dependencies.
package tkhyst_pkg;

    localparam int unsigned SP_W    = 6;
    localparam int unsigned HYST_W  = 8;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned KEY_W   = 5;
    localparam int unsigned ROOM_W  = 12;
    localparam int unsigned DISP_W  = 8;
    localparam int unsigned LED_W   = 8;
    localparam int unsigned IN_W    = 24;
    localparam int unsigned OUT_W   = 24;
    localparam int unsigned ADDR_W  = 5;

    localparam logic [SP_W-1:0]   SP_MIN_RST  = 6'd20;
    localparam logic [SP_W-1:0]   SP_MAX_RST  = 6'd35;
    localparam logic [HYST_W-1:0] HYST_RST    = 8'd16;
    localparam logic [MS_W-1:0]   HOLD_RST    = 16'd5000;
    localparam logic [MS_W-1:0]   PERIOD_RST  = 16'd1000;
    localparam logic [SP_W-1:0]   SETPOINT_RST = 6'd21;
    localparam logic [MS_W-1:0]   MS_SAT      = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TOUCH = 2'd0,
        OP_TEMP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_SP_MIN  = 3'd0,
        REG_SP_MAX  = 3'd1,
        REG_HYST    = 3'd2,
        REG_HOLD    = 3'd3,
        REG_PERIOD  = 3'd4
    } t_reg;

    localparam int unsigned KEY_DEC   = 0;
    localparam int unsigned KEY_FAN   = 1;
    localparam int unsigned KEY_POWER = 2;
    localparam int unsigned KEY_MODE  = 3;
    localparam int unsigned KEY_INC   = 4;

    localparam logic [1:0] MODE_HEAT = 2'd2;
    localparam logic [1:0] MODE_COOL = 2'd3;
    localparam logic [2:0] FAN_AUTO  = 3'd4;

    typedef struct packed {
        logic              beep;
        logic [LED_W-1:0]  status_leds;
        logic [DISP_W-1:0] display_value;
        logic              cool_valve;
        logic              heat_valve;
        logic [2:0]        fan_relays;
        logic              power_on;
    } t_result;

endpackage

// ===== rtl/touch_keypad_hysteresis_thermostat.sv =====
// Touch keypad hysteresis thermostat, top level.
// Throughput: 1 word per cycle while the output is not stalled.
// An input register feeds one combinational update of the thermostat state, whose
// result lands in an output register; both stages advance when the output is free.
// Synchronous active-low reset restores default limits, clears state, set-point 21.
// Depends on tkhyst_pkg.
module touch_keypad_hysteresis_thermostat import tkhyst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // keys[4:0], room_sample[16:5], zero[23:17]
    input  logic [1:0]          s_tuser,   // op[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // power_on[0], fan_relays[3:1], heat_valve[4],
                                           // cool_valve[5], display_value[13:6],
                                           // status_leds[21:14], beep[22], zero[23]
    output logic                m_tuser,   // show_setpoint[0]
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [SP_W-1:0]   r_sp_min, r_sp_max;
    logic [HYST_W-1:0] r_hyst;
    logic [MS_W-1:0]   r_hold_ms, r_period_ms;

    logic              r_in_vld;
    t_op               r_op;
    logic [KEY_W-1:0]  r_keys;
    logic [ROOM_W-1:0] r_sample;

    logic              r_power, n_power;
    logic [2:0]        r_fan, n_fan;
    logic [1:0]        r_mode, n_mode;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_shown, n_shown;
    logic [KEY_W-1:0]  r_prev, n_prev;
    logic [ROOM_W-1:0] r_room, n_room;
    logic [MS_W-1:0]   r_hold, n_hold;
    logic [MS_W-1:0]   r_drive, n_drive;
    logic [2:0]        r_relay, n_relay;
    logic              r_heat, n_heat;
    logic              r_cool, n_cool;
    logic              r_beep, n_beep;

    logic              r_out_vld;
    t_result           r_res, n_res;
    logic              r_show, n_show;

    logic              adv;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        case (reg_idx)
            REG_SP_MIN: prdata = {26'd0, r_sp_min};
            REG_SP_MAX: prdata = {26'd0, r_sp_max};
            REG_HYST:   prdata = {24'd0, r_hyst};
            REG_HOLD:   prdata = {16'd0, r_hold_ms};
            REG_PERIOD: prdata = {16'd0, r_period_ms};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_min    <= SP_MIN_RST;
            r_sp_max    <= SP_MAX_RST;
            r_hyst      <= HYST_RST;
            r_hold_ms   <= HOLD_RST;
            r_period_ms <= PERIOD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SP_MIN: r_sp_min    <= pwdata[SP_W-1:0];
                REG_SP_MAX: r_sp_max    <= pwdata[SP_W-1:0];
                REG_HYST:   r_hyst      <= pwdata[HYST_W-1:0];
                REG_HOLD:   r_hold_ms   <= pwdata[MS_W-1:0];
                REG_PERIOD: r_period_ms <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !r_out_vld || m_tready;
    assign s_tready = !r_in_vld || adv;
    assign m_tvalid = r_out_vld;
    assign m_tdata  = {1'b0, r_res};
    assign m_tuser  = r_show;

    // state update for one word
    logic [KEY_W-1:0]      rise;
    logic signed [13:0]    room_x, sp16, lo_th, hi_th;
    logic [ROOM_W-1:0]     mag;
    logic [ROOM_W:0]       mag_r;
    logic [8:0]            deg;
    logic signed [DISP_W-1:0] room_disp;

    always_comb begin
        n_power = r_power;
        n_fan   = r_fan;
        n_mode  = r_mode;
        n_sp    = r_sp;
        n_shown = r_shown;
        n_prev  = r_prev;
        n_room  = r_room;
        n_hold  = r_hold;
        n_drive = r_drive;
        n_relay = r_relay;
        n_heat  = r_heat;
        n_cool  = r_cool;
        n_beep  = r_beep;
        rise    = r_keys & ~r_prev;

        sp16   = $signed({4'd0, r_sp, 4'd0});
        lo_th  = sp16 - $signed({6'd0, r_hyst});
        hi_th  = sp16 + $signed({6'd0, r_hyst});
        room_x = 14'(signed'(r_room));

        case (r_op)
            OP_TOUCH: begin
                n_beep = 1'b0;
                if (rise[KEY_DEC] && n_power) begin
                    n_beep = 1'b1;
                    n_hold = '0;
                    if (!n_shown) n_shown = 1'b1;
                    else if (n_sp > r_sp_min) n_sp = n_sp - 1'b1;
                end
                if (rise[KEY_FAN] && n_power) begin
                    n_beep = 1'b1;
                    n_fan  = (n_fan < FAN_AUTO) ? n_fan + 1'b1 : 3'd0;
                end
                if (rise[KEY_POWER]) begin
                    n_beep  = 1'b1;
                    n_power = !n_power;
                end
                if (rise[KEY_MODE] && n_power) begin
                    n_beep = 1'b1;
                    n_mode = n_mode + 1'b1;
                end
                if (rise[KEY_INC] && n_power) begin
                    n_beep = 1'b1;
                    n_hold = '0;
                    if (!n_shown) n_shown = 1'b1;
                    else if (n_sp < r_sp_max) n_sp = n_sp + 1'b1;
                end
                n_prev = r_keys;
            end
            OP_TEMP: n_room = r_sample;
            OP_TICK: begin
                if (r_hold != MS_SAT) n_hold = r_hold + 1'b1;
                if (r_drive != MS_SAT) n_drive = r_drive + 1'b1;
                if (r_power) begin
                    if (r_shown && n_hold > r_hold_ms) n_shown = 1'b0;
                    if (n_drive >= r_period_ms) begin
                        n_drive = '0;
                        case (r_fan)
                            3'd0:    n_relay = 3'b000;
                            3'd1:    n_relay = 3'b001;
                            3'd2:    n_relay = 3'b010;
                            3'd3:    n_relay = 3'b100;
                            default: n_relay = r_relay;
                        endcase
                        if (r_mode == MODE_HEAT) begin
                            n_cool = 1'b0;
                            if (room_x < lo_th) n_heat = 1'b1;
                            else if (room_x > hi_th) n_heat = 1'b0;
                        end else if (r_mode == MODE_COOL) begin
                            n_heat = 1'b0;
                            if (room_x > hi_th) n_cool = 1'b1;
                            else if (room_x < lo_th) n_cool = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (!n_power) begin
            n_relay = '0;
            n_heat  = 1'b0;
            n_cool  = 1'b0;
        end

        // round half away from zero, saturate the positive end
        mag   = n_room[ROOM_W-1] ? 12'(-n_room) : n_room;
        mag_r = {1'b0, mag} + 13'd8;
        deg   = mag_r[12:4];
        if (n_room[ROOM_W-1]) room_disp = 8'(-deg);
        else if (deg > 9'd127) room_disp = 8'sd127;
        else room_disp = deg[7:0];

        n_res.power_on   = n_power;
        n_res.fan_relays = n_relay;
        n_res.heat_valve = n_heat;
        n_res.cool_valve = n_cool;
        n_res.beep       = n_beep;
        n_show           = n_power && n_shown;
        if (n_power) begin
            n_res.display_value = n_shown ? {2'b00, n_sp} : room_disp;
            n_res.status_leds   = 8'(1) << n_mode;
            case (n_fan)
                3'd1:    n_res.status_leds[4] = 1'b1;
                3'd2:    n_res.status_leds[5] = 1'b1;
                3'd3:    n_res.status_leds[6] = 1'b1;
                3'd4:    n_res.status_leds[7] = 1'b1;
                default: ;
            endcase
        end else begin
            n_res.display_value = '0;
            n_res.status_leds   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_power   <= 1'b0;
            r_fan     <= '0;
            r_mode    <= '0;
            r_sp      <= SETPOINT_RST;
            r_shown   <= 1'b0;
            r_prev    <= '0;
            r_room    <= '0;
            r_hold    <= '0;
            r_drive   <= '0;
            r_relay   <= '0;
            r_heat    <= 1'b0;
            r_cool    <= 1'b0;
            r_beep    <= 1'b0;
        end else begin
            if (s_tready) r_in_vld <= s_tvalid;
            if (adv) r_out_vld <= r_in_vld;
            if (adv && r_in_vld) begin
                r_power <= n_power;
                r_fan   <= n_fan;
                r_mode  <= n_mode;
                r_sp    <= n_sp;
                r_shown <= n_shown;
                r_prev  <= n_prev;
                r_room  <= n_room;
                r_hold  <= n_hold;
                r_drive <= n_drive;
                r_relay <= n_relay;
                r_heat  <= n_heat;
                r_cool  <= n_cool;
                r_beep  <= n_beep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_op     <= t_op'(s_tuser);
            r_keys   <= s_tdata[KEY_W-1:0];
            r_sample <= s_tdata[KEY_W+ROOM_W-1:KEY_W];
        end
        if (adv && r_in_vld) begin
            r_res  <= n_res;
            r_show <= n_show;
        end
    end

    a_valves_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_heat && r_cool))
        else $error("heat and cool valves open together");

    a_off_clears_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_power |-> (r_relay == 3'd0 && !r_heat && !r_cool))
        else $error("drive outputs active while power is off");

    a_off_blank_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.power_on) |->
        (r_res.status_leds == '0 && r_res.display_value == '0 && !r_show))
        else $error("result shows display data while power is off");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_in_vld) |-> ($stable(r_sp) && $stable(r_power) && $stable(r_mode)))
        else $error("state changed without a word in the input stage");

endmodule
